// ===== hw/rtl/csf_pkg.sv =====
package csf_pkg;

   localparam int LINES = 4096;
   localparam int IDX_W = $clog2(LINES);
   localparam int LINE_W = 12;
   localparam int REQ_W = 24;
   localparam int RSP_W = 16;

   typedef enum logic [2:0] {
      OP_RD_SHARED    = 3'd0,
      OP_RD_OWN       = 3'd1,
      OP_WR_INV       = 3'd2,
      OP_CLR_DEV      = 3'd3,
      OP_CLEAN_EVICT  = 3'd4,
      OP_DIRTY_EVICT  = 3'd5,
      OP_SET_BIAS     = 3'd6,
      OP_NONE         = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_I = 2'd0,
      ST_S = 2'd1,
      ST_E = 2'd2,
      ST_M = 2'd3
   } mesi_type;

   localparam logic [2:0] RESP_INVALID   = 3'd0;
   localparam logic [2:0] RESP_SHARED    = 3'd1;
   localparam logic [2:0] RESP_EXCLUSIVE = 3'd2;
   localparam logic [2:0] RESP_MODIFIED  = 3'd3;
   localparam logic [2:0] RESP_VALID     = 3'd4;

   localparam logic SRC_CPU = 1'b0;
   localparam logic SRC_GPU = 1'b1;

   // one line table entry, bit 0 (present) lowest
   typedef struct packed {
      logic       bias;
      logic       dirty;
      logic       owner;
      logic [1:0] sharers;   // bit 0 cpu, bit 1 gpu
      mesi_type   state;
      logic       present;
   } entry_type;

   // one result, response in the lowest bits
   typedef struct packed {
      logic       evicted;
      logic       host_bias_hit;
      logic       device_bias_hit;
      logic       back_invalidate_event;
      logic       writeback_event;
      logic       was_present;
      logic [2:0] response;
   } result_type;

   typedef struct packed {
      op_type     op;
      logic       requester;
      logic       bias_value;
   } cmd_type;

endpackage

// ===== hw/rtl/coherency_snoop_filter.sv =====
// Path: an accepted request item passes stage 1, then the output register, then rsp_.
// Throughput: one item per cycle while rsp_tready stays high; the line table does
//   one read-modify-write per cycle (read at accept, write when stage 1 fires)
//   with forwarding between back-to-back items to the same line.
// Reset: synchronous, active high. After reset the line table is cleared one
//   entry per cycle with req_tready low; tracking_enable resets to 1.
module coherency_snoop_filter (
   input  logic                          clock,
   input  logic                          reset,
   // request: [2:0] op, [14:3] line_index, [15] requester, [16] bias_value
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [csf_pkg::REQ_W-1:0]     req_tdata,
   // response: [2:0] response, [3] was_present, [4] writeback_event,
   // [5] back_invalidate_event, [6] device_bias_hit, [7] host_bias_hit, [8] evicted
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [csf_pkg::RSP_W-1:0]     rsp_tdata,
   // configuration: tracking_enable
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);
   import csf_pkg::*;

   // line table, one entry per cache line
   entry_type              mem [LINES];

   logic                   enable_ff;
   logic                   clearing_ff;
   logic [IDX_W-1:0]       clr_cnt_ff;

   // stage 1: item waiting for its table read
   logic                   s1_valid_ff;
   cmd_type                s1_cmd_ff;
   logic [IDX_W-1:0]       s1_idx_ff;
   entry_type              rd_data_ff;
   logic                   fwd_hit_ff;
   entry_type              fwd_data_ff;

   // output register
   logic                   rsp_valid_ff;
   result_type             rsp_data_ff;

   logic                   req_accept;
   logic                   s1_fire;
   logic [IDX_W-1:0]       req_idx;
   cmd_type                req_cmd;
   entry_type              s1_entry;
   entry_type              s1_entry_next;
   result_type             s1_result;
   logic [LINE_W-1:0]      req_line;

   assign req_line       = req_tdata[14:3];
   assign req_idx        = req_line[IDX_W-1:0];
   assign req_cmd.op         = op_type'(req_tdata[2:0]);
   assign req_cmd.requester  = req_tdata[15];
   assign req_cmd.bias_value = req_tdata[16];

   // stage 1 advances when the output register is free or being drained
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing_ff && (!s1_valid_ff || s1_fire);
   assign req_accept = req_tvalid && req_tready;

   // take the entry just written by the previous item if it was the same line
   assign s1_entry = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   csf_next u_next (
      .ent             (s1_entry),
      .cmd             (s1_cmd_ff),
      .tracking_enable (enable_ff),
      .ent_next        (s1_entry_next),
      .result          (s1_result)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         enable_ff <= csr_wr_data;
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == IDX_W'(LINES - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // table write port: clear sweep or write-back of stage 1
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (s1_fire) begin
         mem[s1_idx_ff] <= s1_entry_next;
      end
   end

   // table read port, registered
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= mem[req_idx];
      end
   end

   // stage 1 control and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
            fwd_hit_ff  <= s1_fire && (s1_idx_ff == req_idx);
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
            fwd_hit_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff <= req_cmd;
         s1_idx_ff <= req_idx;
      end
      if (s1_fire) begin
         fwd_data_ff <= s1_entry_next;
      end
   end

   // output register: hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= s1_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - $bits(result_type))'(0), rsp_data_ff};

`ifndef SYNTH
   // no item may enter while the table is being cleared
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_tready)
      else $error("request accepted during clearing pass");

   // a finished stage 1 item always lands in the output register
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("stage 1 result lost");

   // with tracking off every answer is the valid code
   a_disabled_valid: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !enable_ff) |=> (rsp_data_ff.response == RESP_VALID))
      else $error("disabled tracking gave a coherency response");

   // an eviction always refers to a line that had an entry
   a_evict_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.evicted) |-> rsp_data_ff.was_present)
      else $error("eviction without a prior entry");
`endif

endmodule

// ===== hw/rtl/csf_next.sv =====
module csf_next (
   input  csf_pkg::entry_type  ent,
   input  csf_pkg::cmd_type    cmd,
   input  logic                tracking_enable,
   output csf_pkg::entry_type  ent_next,
   output csf_pkg::result_type result
);
   import csf_pkg::*;

   logic [1:0] sb;
   logic [1:0] ob;
   logic       src;
   entry_type  e;
   entry_type  fresh;

   assign src = cmd.requester;
   assign sb  = src ? 2'b10 : 2'b01;
   assign ob  = ~sb;

   always_comb begin
      fresh         = '0;
      fresh.present = 1'b1;
      fresh.sharers = sb;
      fresh.owner   = src;
      e             = ent;
      result        = '0;

      if (!tracking_enable) begin
         result.response = RESP_VALID;
      end else begin
         result.was_present = ent.present;
         if (ent.present && (cmd.op == OP_RD_SHARED || cmd.op == OP_RD_OWN)) begin
            result.device_bias_hit = ent.bias && (src == SRC_GPU);
            result.host_bias_hit   = !ent.bias && (src == SRC_CPU);
         end

         case (cmd.op)
            OP_RD_SHARED: begin
               result.response = RESP_SHARED;
               if (!ent.present) begin
                  e       = fresh;
                  e.state = ST_S;
               end else begin
                  if (ent.state == ST_M) begin
                     result.writeback_event = 1'b1;
                     e.state = ST_S;
                     e.dirty = 1'b0;
                  end else if (ent.state == ST_I ||
                               (ent.state == ST_E && ent.owner != src)) begin
                     e.state = ST_S;
                  end
                  e.sharers = ent.sharers | sb;
               end
            end
            OP_RD_OWN: begin
               result.response = RESP_EXCLUSIVE;
               if (!ent.present) begin
                  e = fresh;
               end else if (!(ent.bias && src == SRC_GPU)) begin
                  result.back_invalidate_event = (ent.owner != src) ||
                                                 (|(ent.sharers & ob));
                  if (ent.owner != src && ent.state == ST_M) begin
                     result.writeback_event = 1'b1;
                     e.dirty = 1'b0;
                  end
               end
               e.state   = ST_E;
               e.sharers = sb;
               e.owner   = src;
            end
            OP_WR_INV: begin
               result.response = RESP_MODIFIED;
               if (!ent.present) begin
                  e = fresh;
               end else begin
                  result.back_invalidate_event =
                     (ent.owner != src && ent.state != ST_I) || (|(ent.sharers & ob));
                  result.writeback_event = (ent.owner != src) && (ent.state == ST_M);
               end
               e.state   = ST_M;
               e.sharers = sb;
               e.owner   = src;
               e.dirty   = 1'b1;
            end
            OP_CLR_DEV: begin
               if (ent.present && ent.sharers[1]) begin
                  if (ent.state == ST_M && ent.owner == SRC_GPU) begin
                     result.writeback_event = 1'b1;
                     e.dirty = 1'b0;
                  end
                  e.sharers[1] = 1'b0;
                  e.state      = ent.sharers[0] ? ST_S : ST_I;
               end
            end
            OP_CLEAN_EVICT: begin
               if (ent.present) begin
                  e.sharers = ent.sharers & ob;
                  if ((ent.sharers & ob) == 2'b00) begin
                     e.present      = 1'b0;
                     result.evicted = 1'b1;
                  end
               end
            end
            OP_DIRTY_EVICT: begin
               if (ent.present && ent.owner == src) begin
                  result.writeback_event = 1'b1;
                  e.sharers = ent.sharers & ob;
                  e.dirty   = 1'b0;
                  if ((ent.sharers & ob) == 2'b00) begin
                     e.present      = 1'b0;
                     result.evicted = 1'b1;
                  end else begin
                     e.state = ST_S;
                  end
               end
            end
            OP_SET_BIAS: begin
               if (!ent.present) begin
                  e         = '0;
                  e.present = 1'b1;
               end
               e.bias = cmd.bias_value;
            end
            default: begin
            end
         endcase
      end

      // an entry that is not present is stored as all zeros
      ent_next = e.present ? e : '0;
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

// Testbench for coherency_snoop_filter.
module tb;
   import csf_pkg::*;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   // [2:0] op, [14:3] line_index, [15] requester, [16] bias_value, rest zero
   logic [REQ_W-1:0]   req_tdata   = '0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   // [2:0] response, [3] was_present, [4] writeback_event, [5] back_invalidate_event,
   // [6] device_bias_hit, [7] host_bias_hit, [8] evicted
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_wr_en   = 1'b0;
   logic               csr_wr_data = 1'b0;

   coherency_snoop_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock, low half first
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the line table and of tracking_enable, updated in accept order.
   entry_type  shadow_lines [LINES];
   logic       track_on = 1'b1;
   // Snoop responses owed by the filter, oldest first.
   result_type pending_snoop_results [$];

   int bad_results    = 0;
   int reqs_sent      = 0;
   int untracked_reqs = 0;
   int rsps_checked   = 0;
   // Set to drop all idle gaps on both sides for a stretch of traffic.
   logic burst_mode = 1'b0;
   int   rsp_stall  = 0;

   function automatic int pick_gap();
      return burst_mode ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic entry_type fresh_line(mesi_type st, logic src);
      entry_type e;
      e = '0;
      e.present = 1'b1;
      e.state   = st;
      e.sharers = src ? 2'b10 : 2'b01;
      e.owner   = src;
      return e;
   endfunction

   // Apply one request to the shadow table and return the snoop response it earns.
   function automatic result_type coherency_update(op_type op, logic [LINE_W-1:0] line,
                                                   logic src, logic bv);
      entry_type  e;
      result_type r;
      logic [1:0] own_bit;
      logic [1:0] peer_bit;
      r = '0;
      // tracking off: answer valid, leave the table alone
      if (!track_on) begin
         r.response = RESP_VALID;
         return r;
      end
      e        = shadow_lines[line];
      own_bit  = src ? 2'b10 : 2'b01;
      peer_bit = ~own_bit;
      r.was_present = e.present;
      if (e.present && (op == OP_RD_SHARED || op == OP_RD_OWN)) begin
         r.device_bias_hit = e.bias && src;
         r.host_bias_hit   = !e.bias && !src;
      end
      case (op)
         OP_RD_SHARED: begin
            r.response = RESP_SHARED;
            if (!e.present) begin
               e = fresh_line(ST_S, src);
            end else begin
               // modified data gets written back and the line drops to shared
               if (e.state == ST_M) begin
                  r.writeback_event = 1'b1;
                  e.state = ST_S;
                  e.dirty = 1'b0;
               end else if (e.state == ST_I || (e.state == ST_E && e.owner != src)) begin
                  e.state = ST_S;
               end
               e.sharers |= own_bit;
            end
         end
         OP_RD_OWN: begin
            r.response = RESP_EXCLUSIVE;
            if (!e.present) begin
               e = fresh_line(ST_E, src);
            end else if (!(e.bias && src)) begin
               // a gpu request to a device-biased line skips the snoop
               if (e.owner != src || (e.sharers & peer_bit) != 0)
                  r.back_invalidate_event = 1'b1;
               if (e.owner != src && e.state == ST_M) begin
                  r.writeback_event = 1'b1;
                  e.dirty = 1'b0;
               end
            end
            e.state   = ST_E;
            e.sharers = own_bit;
            e.owner   = src;
         end
         OP_WR_INV: begin
            r.response = RESP_MODIFIED;
            if (!e.present) begin
               e = fresh_line(ST_M, src);
            end else begin
               if ((e.owner != src && e.state != ST_I) || (e.sharers & peer_bit) != 0)
                  r.back_invalidate_event = 1'b1;
               if (e.owner != src && e.state == ST_M)
                  r.writeback_event = 1'b1;
            end
            e.state   = ST_M;
            e.sharers = own_bit;
            e.owner   = src;
            e.dirty   = 1'b1;
         end
         OP_CLR_DEV: begin
            // only lines the gpu holds are touched; the entry itself stays
            if (e.present && e.sharers[1]) begin
               if (e.state == ST_M && e.owner == SRC_GPU) begin
                  r.writeback_event = 1'b1;
                  e.dirty = 1'b0;
               end
               e.sharers[1] = 1'b0;
               e.state = (e.sharers != 0) ? ST_S : ST_I;
            end
         end
         OP_CLEAN_EVICT: begin
            if (e.present) begin
               e.sharers &= peer_bit;
               if (e.sharers == 0) begin
                  e.present = 1'b0;
                  r.evicted = 1'b1;
               end
            end
         end
         OP_DIRTY_EVICT: begin
            // ignored unless the requester owns the line
            if (e.present && e.owner == src) begin
               r.writeback_event = 1'b1;
               e.sharers &= peer_bit;
               e.dirty = 1'b0;
               if (e.sharers == 0) begin
                  e.present = 1'b0;
                  r.evicted = 1'b1;
               end else begin
                  e.state = ST_S;
               end
            end
         end
         OP_SET_BIAS: begin
            if (e.present) begin
               e.bias = bv;
            end else begin
               e = fresh_line(ST_I, SRC_CPU);
               e.sharers = 2'b00;
               e.bias = bv;
            end
         end
         default: ;
      endcase
      if (!e.present)
         e = '0;
      shadow_lines[line] = e;
      return r;
   endfunction

   // Response side backpressure: after each item, hold tready low for a random stretch.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         rsp_stall = pick_gap();
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each response item with the oldest one owed.
   always @(posedge clock) begin : check_rsp
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (pending_snoop_results.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
               $display("%0t: response item %h with none outstanding", $realtime, rsp_tdata);
         end else begin
            want = pending_snoop_results.pop_front();
            rsps_checked++;
            if (got.response !== want.response || got.was_present !== want.was_present ||
                got.writeback_event !== want.writeback_event ||
                got.back_invalidate_event !== want.back_invalidate_event ||
                got.device_bias_hit !== want.device_bias_hit ||
                got.host_bias_hit !== want.host_bias_hit || got.evicted !== want.evicted) begin
               bad_results++;
               if (bad_results <= 10) begin
                  $display("%0t: mismatch, expected rsp=%0d pr=%b wb=%b bi=%b dh=%b hh=%b ev=%b",
                           $realtime, want.response, want.was_present, want.writeback_event,
                           want.back_invalidate_event, want.device_bias_hit,
                           want.host_bias_hit, want.evicted);
                  $display("   got rsp=%0d pr=%b wb=%b bi=%b dh=%b hh=%b ev=%b",
                           got.response, got.was_present, got.writeback_event,
                           got.back_invalidate_event, got.device_bias_hit,
                           got.host_bias_hit, got.evicted);
               end
            end
         end
      end
   end

   // Offer one request after a random gap; predict its response once it is taken.
   task automatic send_req(input op_type op, input logic [LINE_W-1:0] line,
                           input logic src, input logic bv);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - 17){1'b0}}, bv, src, line, op};
      do @(posedge clock); while (!req_tready);
      pending_snoop_results.push_back(coherency_update(op, line, src, bv));
      reqs_sent++;
      if (!track_on)
         untracked_reqs++;
   endtask

   // Stop sending and wait until every owed response has come back.
   task automatic drain_filter();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_snoop_results.size() != 0);
   endtask

   // Write tracking_enable; call only while the filter is idle.
   task automatic set_tracking(input logic on);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      track_on = on;
      csr_wr_en <= 1'b0;
   endtask

   // Walk the MESI transitions and the corner cases on a few fixed lines.
   task automatic test_directed();
      // back to back first, so same-line forwarding is exercised
      burst_mode = 1'b1;
      send_req(OP_RD_OWN,      12'd0,    SRC_CPU, 1'b0); // new line, exclusive
      send_req(OP_RD_SHARED,   12'd0,    SRC_GPU, 1'b1); // E owned by other -> S
      send_req(OP_WR_INV,      12'd0,    SRC_CPU, 1'b0); // owner, peer sharer -> binv
      send_req(OP_RD_SHARED,   12'd0,    SRC_GPU, 1'b0); // M -> writeback, S
      send_req(OP_CLR_DEV,     12'd0,    SRC_GPU, 1'b0); // cpu remains -> S
      send_req(OP_CLR_DEV,     12'd0,    SRC_CPU, 1'b0); // no gpu sharer, no change
      send_req(OP_DIRTY_EVICT, 12'd0,    SRC_GPU, 1'b0); // not owner, no change
      send_req(OP_DIRTY_EVICT, 12'd0,    SRC_CPU, 1'b0); // owner -> writeback, evict
      send_req(OP_NONE,        12'd0,    SRC_CPU, 1'b0); // absent line
      send_req(OP_SET_BIAS,    12'hFFF,  SRC_GPU, 1'b1); // creates I, device bias
      send_req(OP_RD_SHARED,   12'hFFF,  SRC_GPU, 1'b0); // I -> S, device hit
      send_req(OP_RD_OWN,      12'hFFF,  SRC_GPU, 1'b0); // device bias gpu, no snoop
      burst_mode = 1'b0;
      send_req(OP_WR_INV,      12'hFFF,  SRC_CPU, 1'b1); // other owner in E -> binv
      send_req(OP_CLEAN_EVICT, 12'hFFF,  SRC_GPU, 1'b0); // not a sharer, stays
      send_req(OP_NONE,        12'hFFF,  SRC_GPU, 1'b1); // present line
      send_req(OP_SET_BIAS,    12'hFFF,  SRC_CPU, 1'b0); // back to host bias
      send_req(OP_RD_SHARED,   12'hFFF,  SRC_CPU, 1'b0); // host hit, M -> writeback
      send_req(OP_CLEAN_EVICT, 12'hFFF,  SRC_CPU, 1'b0); // last sharer -> evict
      send_req(OP_WR_INV,      12'hAAA,  SRC_GPU, 1'b0); // new line, modified
      send_req(OP_CLR_DEV,     12'hAAA,  SRC_GPU, 1'b0); // gpu owns M -> wb, I
      send_req(OP_RD_OWN,      12'hAAA,  SRC_CPU, 1'b1); // I, other owner -> binv
      send_req(OP_RD_SHARED,   12'h555,  SRC_CPU, 1'b1);
      send_req(OP_NONE,        12'h555,  SRC_GPU, 1'b1);
   endtask

   // With tracking off every op answers valid and the table must not move.
   task automatic test_tracking_off();
      int i;
      drain_filter();
      set_tracking(1'b0);
      for (i = 0; i < 8; i++)
         send_req(op_type'(i), i[0] ? 12'hFFF : 12'h000, i[1], i[2]);
      for (i = 0; i < 24; i++)
         send_req(op_type'($urandom_range(0, 7)), LINE_W'($urandom_range(0, LINES - 1)),
                  1'($urandom), 1'($urandom));
      drain_filter();
      set_tracking(1'b1);
      // revisit lines the directed part left in known states
      send_req(OP_NONE,      12'h000, SRC_CPU, 1'b0);
      send_req(OP_NONE,      12'hAAA, SRC_GPU, 1'b1);
      send_req(OP_RD_SHARED, 12'h555, SRC_GPU, 1'b0);
   endtask

   // Random ops, mostly aimed at a small set of hot lines so entries cycle through
   // every state; the rest spread over the whole table. Tracking is toggled between
   // bursts now and then.
   task automatic test_random_traffic(input int bursts, input int per_burst);
      logic [LINE_W-1:0] hot_lines [6];
      logic [LINE_W-1:0] line;
      int                b;
      int                i;
      for (b = 0; b < bursts; b++) begin
         drain_filter();
         set_tracking(b == 0 ? 1'b1 : ($urandom_range(0, 4) != 0));
         foreach (hot_lines[k])
            hot_lines[k] = LINE_W'($urandom_range(0, LINES - 1));
         for (i = 0; i < per_burst; i++) begin
            if (i % 30 == 0)
               burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
               line = hot_lines[$urandom_range(0, 5)];
            else
               line = LINE_W'($urandom_range(0, LINES - 1));
            send_req(op_type'($urandom_range(0, 7)), line, 1'($urandom), 1'($urandom));
         end
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      foreach (shadow_lines[k])
         shadow_lines[k] = '0;
      // hold reset; the filter then clears its table with req_tready low
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_tracking(1'b1);
      test_directed();
      test_tracking_off();
      test_random_traffic(12, 150);
      drain_filter();
      // let any stray response item surface
      repeat (4) @(posedge clock);
      $display("Sent %0d snoop requests (%0d with tracking off), checked %0d responses,",
               reqs_sent, untracked_reqs, rsps_checked);
      $display("  covering all ops, both requesters and biases, and the table edges.");
      if (bad_results == 0 && pending_snoop_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Give up long after the slowest correct run would have ended.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/csf_pkg.sv
hw/rtl/csf_next.sv
hw/rtl/coherency_snoop_filter.sv
dv/tb.sv
